// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EDF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define EDF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
// Types and constants of the EDF task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam int unsigned TASK_ID_W = 8;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned REPORT_W  = 3;
  localparam int unsigned QUANTUM_W = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  localparam logic REG_IDX_QUANTUM = 1'b0;

  typedef enum logic [REPORT_W-1:0] {
    REP_ADD_OK   = 3'd0,
    REP_FULL     = 3'd1,
    REP_MISS     = 3'd2,
    REP_DISPATCH = 3'd3,
    REP_IDLE     = 3'd4
  } report_e;

  typedef struct packed {
    logic [TASK_ID_W-1:0] id;
    logic [TIME_W-1:0]    dl;
    logic [BURST_W-1:0]   rem;
  } task_entry_t;

endpackage

`default_nettype wire

// ===== rtl/edf_task_scheduler_unit.sv =====
// EDF task scheduler: task table in RAM, sequential scan, dispatch and compaction.
//
// An add item is answered from the start state. A schedule item on a non-empty
// table scans the N stored tasks through the single read port of the task RAM
// (one entry per cycle while no missed-deadline result is stalled), then
// dispatches, and when the chosen task finishes, moves each entry behind it
// down, one per cycle, to close the gap. A stall on the result side holds the item.
// A new item is taken only once the previous one has placed all its results;
// the last result may still wait in the output register. Results carry last
// high on the final transfer of each item. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module edf_task_scheduler_unit #(
  parameter int unsigned MaxTasks = edf_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [edf_pkg::TASK_ID_W-1:0]  task_id_i,
  input  logic [edf_pkg::BURST_W-1:0]    burst_i,
  input  logic [edf_pkg::TIME_W-1:0]     deadline_i,
  input  logic [edf_pkg::TIME_W-1:0]     now_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [edf_pkg::REPORT_W-1:0]   report_o,
  output logic [edf_pkg::TASK_ID_W-1:0]  out_task_o,
  output logic [edf_pkg::TIME_W-1:0]     out_deadline_o,
  output logic [edf_pkg::BURST_W-1:0]    run_ticks_o,
  output logic                           finished_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [edf_pkg::PADDR_W-1:0]    paddr,
  input  logic [edf_pkg::PDATA_W-1:0]    pwdata,
  output logic [edf_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  import edf_pkg::*;

  localparam int unsigned IdxW   = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW   = $clog2(MaxTasks + 1);
  localparam int unsigned EntryW = $bits(task_entry_t);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DISP  = 5'b01000,
    S_MOVE  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       raddr_q, raddr_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  task_entry_t           best_q, best_d;
  logic [QUANTUM_W-1:0]  quantum_q;

  logic                  kind_q;
  logic [TASK_ID_W-1:0]  task_id_q;
  logic [BURST_W-1:0]    burst_q;
  logic [TIME_W-1:0]     deadline_q;
  logic [TIME_W-1:0]     now_q;

  logic                  out_valid_q;
  report_e               report_q;
  logic [TASK_ID_W-1:0]  out_task_q;
  logic [TIME_W-1:0]     out_deadline_q;
  logic [BURST_W-1:0]    run_ticks_q;
  logic                  finished_q;
  logic                  last_q;

  logic                  emit;
  report_e               emit_rep;
  logic [TASK_ID_W-1:0]  emit_id;
  logic [TIME_W-1:0]     emit_dl;
  logic [BURST_W-1:0]    emit_ticks;
  logic                  emit_fin;
  logic                  emit_last;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  task_entry_t           mem_wdata;
  logic [EntryW-1:0]     mem_rdata;
  task_entry_t           rd_entry;

  logic                  in_accept;
  logic                  out_free;
  logic                  tbl_full;
  logic [CntW-1:0]       last_idx;
  logic                  scan_at_end;
  logic                  best_at_end;
  logic                  miss;
  logic [BURST_W-1:0]    disp_ticks;
  logic [BURST_W-1:0]    disp_rem;
  logic                  disp_fin;
  logic                  cfg_write;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_entry   = task_entry_t'(mem_rdata);

  assign tbl_full    = (count_q == CntW'(MaxTasks));
  assign last_idx    = count_q - CntW'(1);
  assign scan_at_end = (CntW'(raddr_q) == last_idx);
  assign best_at_end = (CntW'(best_idx_q) == last_idx);
  assign miss        = (now_q > rd_entry.dl);

  assign disp_ticks = (best_q.rem < quantum_q) ? best_q.rem : quantum_q;
  assign disp_rem   = best_q.rem - disp_ticks;
  assign disp_fin   = (disp_rem == '0);

  edf_ram #(
    .Width (EntryW),
    .Depth (MaxTasks)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr_d),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    raddr_d    = raddr_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    emit       = 1'b0;
    emit_rep   = REP_ADD_OK;
    emit_id    = '0;
    emit_dl    = '0;
    emit_ticks = '0;
    emit_fin   = 1'b0;
    emit_last  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = raddr_q;
    mem_wdata  = rd_entry;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (out_free) begin
          if (kind_q == KIND_ADD) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            state_d   = S_IDLE;
            if (tbl_full) begin
              emit_rep = REP_FULL;
            end else begin
              emit_rep      = REP_ADD_OK;
              mem_we        = 1'b1;
              mem_waddr     = count_q[IdxW-1:0];
              mem_wdata.id  = task_id_q;
              mem_wdata.dl  = deadline_q;
              mem_wdata.rem = burst_q;
              count_d       = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            emit      = 1'b1;
            emit_rep  = REP_IDLE;
            emit_last = 1'b1;
            state_d   = S_IDLE;
          end else begin
            raddr_d = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!miss || out_free) begin
          if (miss) begin
            emit     = 1'b1;
            emit_rep = REP_MISS;
            emit_id  = rd_entry.id;
            emit_dl  = rd_entry.dl;
          end
          if ((raddr_q == '0) || (rd_entry.dl < best_q.dl)) begin
            best_idx_d = raddr_q;
            best_d     = rd_entry;
          end
          if (scan_at_end) begin
            state_d = S_DISP;
          end else begin
            raddr_d = raddr_q + IdxW'(1);
          end
        end
      end
      S_DISP: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_rep   = REP_DISPATCH;
          emit_id    = best_q.id;
          emit_dl    = best_q.dl;
          emit_ticks = disp_ticks;
          emit_fin   = disp_fin;
          emit_last  = 1'b1;
          state_d    = S_IDLE;
          if (!disp_fin) begin
            mem_we        = 1'b1;
            mem_waddr     = best_idx_q;
            mem_wdata     = best_q;
            mem_wdata.rem = disp_rem;
          end else if (best_at_end) begin
            count_d = count_q - CntW'(1);
          end else begin
            raddr_d = best_idx_q + IdxW'(1);
            state_d = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = raddr_q - IdxW'(1);
        mem_wdata = rd_entry;
        if (scan_at_end) begin
          count_d = count_q - CntW'(1);
          state_d = S_IDLE;
        end else begin
          raddr_d = raddr_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q    <= raddr_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    if (in_accept) begin
      kind_q     <= kind_i;
      task_id_q  <= task_id_i;
      burst_q    <= burst_i;
      deadline_q <= deadline_i;
      now_q      <= now_i;
    end
    if (emit) begin
      report_q       <= emit_rep;
      out_task_q     <= emit_id;
      out_deadline_q <= emit_dl;
      run_ticks_q    <= emit_ticks;
      finished_q     <= emit_fin;
      last_q         <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_o       = report_q;
  assign out_task_o     = out_task_q;
  assign out_deadline_o = out_deadline_q;
  assign run_ticks_o    = run_ticks_q;
  assign finished_o     = finished_q;
  assign last_o         = last_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[PADDR_W-1] == REG_IDX_QUANTUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_write) begin
      quantum_q <= pwdata[QUANTUM_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1])
      REG_IDX_QUANTUM: prdata = {{(PDATA_W - QUANTUM_W){1'b0}}, quantum_q};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/edf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module edf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/edf_checker.sv =====
// Port-level checker for the EDF task scheduler, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module edf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [edf_pkg::REPORT_W-1:0]  report_o,
  input logic [edf_pkg::TASK_ID_W-1:0] out_task_o,
  input logic [edf_pkg::TIME_W-1:0]    out_deadline_o,
  input logic [edf_pkg::BURST_W-1:0]   run_ticks_o,
  input logic                          finished_o,
  input logic                          last_o
);

  import edf_pkg::*;

  `EDF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(report_o) && $stable(out_task_o) && $stable(last_o),
    "stalled result transfer changed")

  `EDF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o, "input taken while previous item still in work")

  `EDF_ASSERT_IMP(a_single_results, clk_i, rst_ni,
    out_valid_o && (report_o == REP_ADD_OK || report_o == REP_FULL
                    || report_o == REP_IDLE),
    last_o && !finished_o && (run_ticks_o == '0) && (out_task_o == '0),
    "add or idle result is not a lone final transfer")

  `EDF_ASSERT_IMP(a_miss_not_last, clk_i, rst_ni,
    out_valid_o && (report_o == REP_MISS),
    !last_o && !finished_o && (run_ticks_o == '0),
    "missed-deadline result closed an item")

  `EDF_ASSERT_IMP(a_finish_on_dispatch, clk_i, rst_ni, out_valid_o && finished_o,
    (report_o == REP_DISPATCH) && last_o,
    "finished flag on a result other than dispatch")

endmodule

bind edf_task_scheduler_unit edf_checker u_edf_checker (.*);

`default_nettype wire
